### rtl/rcms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// shared types and constants for the reversing conveyor motor sequencer
// no dependencies
package rcms_pkg;

	localparam int unsigned MS_PER_SECOND = 1000;

	localparam int unsigned CFG_W   = 16;
	localparam int unsigned PHASE_W = 16;
	localparam int unsigned SUBS_W  = 10;
	localparam int unsigned SECS_W  = 16;
	localparam int unsigned ADDR_W  = 2;

	// register reset values
	localparam logic [CFG_W-1:0] RUN_SECONDS_RST      = 16'd240;
	localparam logic [CFG_W-1:0] REVERSE_PAUSE_MS_RST = 16'd500;
	localparam logic [CFG_W-1:0] DEBOUNCE_MS_RST      = 16'd200;

	// register indexes
	localparam logic [ADDR_W-1:0] REG_RUN_SECONDS      = 2'd0;
	localparam logic [ADDR_W-1:0] REG_REVERSE_PAUSE_MS = 2'd1;
	localparam logic [ADDR_W-1:0] REG_DEBOUNCE_MS      = 2'd2;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_PRESS   = 3'd1,
		MODE_WAITREL = 3'd2,
		MODE_RELEASE = 3'd3,
		MODE_RUN     = 3'd4,
		MODE_PAUSE   = 3'd5,
		MODE_LOCK    = 3'd6
	} mode_t;

	// fields of one input beat, last field in bit 0
	typedef struct packed {
		logic left_switch;
		logic right_switch;
		logic button_pressed;
	} in_item_t;

	// fields of one result beat, last field in bit 0
	typedef struct packed {
		logic run_active;
		logic left_relay;
		logic right_relay;
	} out_item_t;

endpackage
`default_nettype wire

### rtl/reversing_conveyor_motor_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// reversing conveyor motor sequencer, top level
// depends on rcms_pkg
//
// One input beat is one millisecond tick carrying the sampled start button and
// the two limit-switch levels; every beat produces exactly one result beat with
// the right and left direction relays and the run flag. A debounced press and
// release of the button starts a timed run driving right. While running, a
// pressed limit switch drops the opposite relay, waits reverse_pause_ms ticks
// and then energizes its own relay; both switches together force an interlock
// that drops both relays and holds the run clock until they release. The run
// ends after run_seconds seconds counted in ticks. The whole state update is
// one pass of small counter and compare logic that writes the state registers
// and the result register together, so a new beat is taken every cycle as long
// as the result register is empty or being drained in the same cycle. The
// result beat is registered and offered in the cycle after its input beat is
// accepted. Configuration is a plain write port (cfg_we, cfg_addr, cfg_wdata);
// index 0 is run_seconds, 1 reverse_pause_ms, 2 debounce_ms; index 3 is
// ignored. Write registers only while the block is idle.
module reversing_conveyor_motor_sequencer import rcms_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration write port
	input  wire logic              cfg_we,
	input  wire logic [ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_W-1:0]  cfg_wdata,
	// input beats
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [7:0]        s_axis_tdata,   // [0] button_pressed, [1] right_switch,
	                                               // [2] left_switch, [7:3] zero
	// result beats
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [7:0]             m_axis_tdata    // [0] right_relay, [1] left_relay,
	                                               // [2] run_active, [7:3] zero
);

	// configuration registers
	logic [CFG_W-1:0] run_seconds_q;
	logic [CFG_W-1:0] reverse_pause_ms_q;
	logic [CFG_W-1:0] debounce_ms_q;

	// sequencer state
	mode_t              mode_q, mode_d;
	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [SUBS_W-1:0]  subs_q, subs_d;
	logic [SECS_W-1:0]  secs_q, secs_d;
	logic               right_on_q, right_on_d;
	logic               left_on_q, left_on_d;
	logic               armed_q, armed_d;
	logic               pend_right_q, pend_right_d;

	// result register
	logic      out_valid_q;
	out_item_t out_item_q, out_item_d;

	in_item_t in_item;
	logic     accept;
	logic     both;

	// saturating increments and the run clock step
	logic [PHASE_W-1:0] phase_inc;
	logic [SUBS_W-1:0]  subs_tick;
	logic [SECS_W-1:0]  secs_tick;
	logic               sec_wrap;

	assign in_item       = s_axis_tdata[2:0];
	assign both          = in_item.right_switch & in_item.left_switch;

	// result register empties or drains this cycle
	assign s_axis_tready = ~out_valid_q | m_axis_tready;
	assign accept        = s_axis_tvalid & s_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_item_q};

	assign phase_inc = (phase_q == {PHASE_W{1'b1}}) ? phase_q : phase_q + 1'b1;
	// subsecond rolls over at one second
	assign sec_wrap  = ({1'b0, subs_q} + 1'b1) >= (SUBS_W+1)'(MS_PER_SECOND);
	assign subs_tick = sec_wrap ? '0 : subs_q + 1'b1;
	assign secs_tick = (sec_wrap && secs_q != {SECS_W{1'b1}}) ? secs_q + 1'b1 : secs_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_seconds_q      <= RUN_SECONDS_RST;
			reverse_pause_ms_q <= REVERSE_PAUSE_MS_RST;
			debounce_ms_q      <= DEBOUNCE_MS_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_RUN_SECONDS:      run_seconds_q      <= cfg_wdata;
				REG_REVERSE_PAUSE_MS: reverse_pause_ms_q <= cfg_wdata;
				REG_DEBOUNCE_MS:      debounce_ms_q      <= cfg_wdata;
				default:              ;
			endcase
		end
	end

	// next state for one tick
	always_comb begin
		mode_d       = mode_q;
		phase_d      = phase_q;
		subs_d       = subs_q;
		secs_d       = secs_q;
		right_on_d   = right_on_q;
		left_on_d    = left_on_q;
		armed_d      = armed_q;
		pend_right_d = pend_right_q;

		unique case (mode_q)
			MODE_PRESS: begin
				phase_d = phase_inc;
				if (phase_inc >= debounce_ms_q) mode_d = MODE_WAITREL;
			end
			MODE_WAITREL: begin
				if (!in_item.button_pressed) begin
					phase_d = '0;
					mode_d  = MODE_RELEASE;
				end
			end
			MODE_RELEASE: begin
				phase_d = phase_inc;
				if (phase_inc >= debounce_ms_q) begin
					armed_d      = 1'b1;
					subs_d       = '0;
					secs_d       = '0;
					right_on_d   = 1'b1;
					pend_right_d = 1'b0;
					mode_d       = MODE_RUN;
				end
			end
			MODE_RUN, MODE_PAUSE: begin
				if (both) begin
					// interlock: drop everything, abort any dead time
					right_on_d   = 1'b0;
					left_on_d    = 1'b0;
					armed_d      = 1'b0;
					pend_right_d = 1'b0;
					subs_d       = '0;
					mode_d       = MODE_LOCK;
				end else if (secs_tick >= run_seconds_q) begin
					// run over
					right_on_d   = 1'b0;
					left_on_d    = 1'b0;
					armed_d      = 1'b0;
					pend_right_d = 1'b0;
					subs_d       = '0;
					secs_d       = '0;
					mode_d       = MODE_IDLE;
				end else begin
					subs_d = subs_tick;
					secs_d = secs_tick;
					if (in_item.button_pressed && !armed_q) begin
						// restart: relays hold, clock freezes
						pend_right_d = 1'b0;
						phase_d      = '0;
						mode_d       = MODE_PRESS;
					end else if (mode_q == MODE_PAUSE) begin
						phase_d = phase_inc;
						if (phase_inc >= reverse_pause_ms_q) begin
							if (pend_right_q) right_on_d = 1'b1;
							else              left_on_d  = 1'b1;
							pend_right_d = 1'b0;
							mode_d       = MODE_RUN;
						end
					end else if (in_item.right_switch) begin
						left_on_d    = 1'b0;
						pend_right_d = 1'b1;
						phase_d      = '0;
						mode_d       = MODE_PAUSE;
					end else if (in_item.left_switch) begin
						right_on_d   = 1'b0;
						pend_right_d = 1'b0;
						phase_d      = '0;
						mode_d       = MODE_PAUSE;
					end
				end
			end
			MODE_LOCK: begin
				if (!both) mode_d = MODE_RUN;
			end
			default: begin
				// idle and the unused code
				mode_d = MODE_IDLE;
				if (!both && in_item.button_pressed) begin
					phase_d = '0;
					mode_d  = MODE_PRESS;
				end
			end
		endcase

		out_item_d.right_relay = right_on_d;
		out_item_d.left_relay  = left_on_d;
		out_item_d.run_active  = (mode_d == MODE_RUN) || (mode_d == MODE_PAUSE) ||
		                         (mode_d == MODE_LOCK);
	end

	// state advances once per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			phase_q      <= '0;
			subs_q       <= '0;
			secs_q       <= '0;
			right_on_q   <= 1'b0;
			left_on_q    <= 1'b0;
			armed_q      <= 1'b0;
			pend_right_q <= 1'b0;
		end else if (accept) begin
			mode_q       <= mode_d;
			phase_q      <= phase_d;
			subs_q       <= subs_d;
			secs_q       <= secs_d;
			right_on_q   <= right_on_d;
			left_on_q    <= left_on_d;
			armed_q      <= armed_d;
			pend_right_q <= pend_right_d;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) out_item_q <= out_item_d;
	end

endmodule
`default_nettype wire

### rtl/rcms_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// port-level checks for the reversing conveyor motor sequencer
// attached to the top level by the bind at the end of this file
module rcms_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_axis_tvalid,
	input wire logic       s_axis_tready,
	input wire logic [7:0] s_axis_tdata,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata
);

	// every accepted beat shows a result on the next cycle
	a_beat_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("accepted beat produced no result");

	// an empty result register never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty result register");

	// a stalled result stays offered
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result withdrawn while stalled");

	// a stalled result keeps its payload
	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result payload changed while stalled");

endmodule

bind reversing_conveyor_motor_sequencer rcms_checker u_rcms_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
